@@ hdl/dps_pkg.sv @@
// Shared types and constants for the deadline penalty scheduler.
package dps_pkg;
  localparam int MAX_JOBS_DEF = 32;
  localparam int DL_W = 6;
  localparam int PEN_W = 16;
  localparam int SUM_W = 21;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic KIND_TOTAL = 1'b0;
  localparam logic KIND_DAY = 1'b1;

  typedef struct packed {
    logic [DL_W-1:0] deadline;
    logic [PEN_W-1:0] penalty;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic [5:0] day;
    logic [5:0] job_id;
    logic [SUM_W-1:0] total_penalty;
    logic final_res;
  } out_item_t;

  // Per-cell job record: sort key and identity.
  typedef struct packed {
    logic vld;
    logic [DL_W-1:0] dl;
    logic [PEN_W-1:0] pen;
    logic [5:0] id;
  } job_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    job_t job;
    logic shift;
    logic clr;
  } cell_cmd_t;
endpackage

@@ hdl/dps_cell.sv @@
// One cell of the sorting chain: holds a job, inserts in order, shifts out.
module dps_cell (
  input  logic clk,
  input  logic rst_n,
  input  dps_pkg::cell_cmd_t cmd,
  input  dps_pkg::job_t prev_job,
  input  logic prev_goes,
  input  dps_pkg::job_t next_job,
  output dps_pkg::job_t job,
  output logic goes
);
  dps_pkg::job_t job_r, job_nxt;

  function automatic logic sorts_before(dps_pkg::job_t a, dps_pkg::job_t b);
    if (!b.vld) return 1'b1;
    if (a.dl != b.dl) return a.dl < b.dl;
    if (a.pen != b.pen) return a.pen > b.pen;
    return a.id < b.id;
  endfunction

  assign goes = sorts_before(cmd.job, job_r);

  always_comb begin
    job_nxt = job_r;
    if (cmd.clr) job_nxt.vld = 1'b0;
    else if (cmd.shift) job_nxt = next_job;
    else if (cmd.ins && goes) job_nxt = prev_goes ? prev_job : cmd.job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) job_r.vld <= 1'b0;
    else begin
      job_r <= job_nxt;
    end
  end

  assign job = job_r;
endmodule

@@ hdl/dps_chain.sv @@
// Row of sorting cells ordered by deadline, penalty desc, id.
module dps_chain #(
  parameter int MAX_JOBS = dps_pkg::MAX_JOBS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  dps_pkg::cell_cmd_t cmd,
  output dps_pkg::job_t head
);
  dps_pkg::job_t jobs [MAX_JOBS+1];
  logic goes [MAX_JOBS+1];

  assign goes[0] = 1'b0;
  assign jobs[0] = '0;

  for (genvar i = 1; i <= MAX_JOBS; i++) begin : g_cell
    dps_pkg::job_t nxt;
    if (i == MAX_JOBS) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = jobs[i+1];
    end
    dps_cell u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd),
      .prev_job(jobs[i-1]), .prev_goes(goes[i-1]),
      .next_job(nxt), .job(jobs[i]), .goes(goes[i])
    );
  end

  assign head = jobs[1];
endmodule

@@ hdl/deadline_penalty_scheduler_unit.sv @@
// Top level of the deadline penalty scheduler.
// Usage: jobs enter on in_valid/in_ready, one transaction per job; the
// job id is the 1-based arrival order. in_ready stays high while loading.
// A job with last set starts the computation; in_ready stays low until
// every result is delivered. Jobs beyond MAX_JOBS are dropped, but their
// last bit still starts the run.
// Sorting happens during loading in the cell chain (one insertion per
// cycle). After last, the chain shifts out the jobs one at a time into
// the heap phase, the next only once the push and any pop of the last
// are done; a push walks up and a pop walks down one level per cycle.
// Slot assignment scans all n ids for every deadline 1..n; each kept
// job steps down over occupied days to the latest free day at or before
// its deadline. Filling then gives each free day the next late job in
// id order. The slot scan sets most of the time before the first result.
// Results leave on out_valid/out_ready: first the total penalty, then one
// transaction per day 1..n, one per cycle while out_ready is high, final_res on the last.
// Output is held in a register; a stalled receiver freezes the sequencer.
// Reset clears the job count, the chain and all flags; no clearing pass.
module deadline_penalty_scheduler_unit #(
  parameter int MAX_JOBS = dps_pkg::MAX_JOBS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  dps_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output dps_pkg::out_item_t out_data
);
  localparam int IW = $clog2(MAX_JOBS + 1);
  localparam int AW = $clog2(MAX_JOBS) > 0 ? $clog2(MAX_JOBS) : 1;

  typedef enum logic [3:0] {
    S_LOAD, S_DRAIN, S_PUSH_UP, S_POP_START, S_POP_DOWN, S_SLOT_INIT,
    S_SLOT_FIND, S_SLOT_LINK, S_FILL, S_OUT_TOTAL, S_OUT_DAY
  } state_t;

  state_t state_r;
  logic [IW-1:0] n_r, cnt_r, hsz_r, k_r, d_r, ptr_r, root_r, idx_r;
  logic [dps_pkg::SUM_W-1:0] sum_r;
  logic [IW-1:0] heap_r [MAX_JOBS];
  logic [dps_pkg::PEN_W-1:0] pen_r [MAX_JOBS];
  logic [dps_pkg::DL_W-1:0] edl_r [MAX_JOBS];
  logic [MAX_JOBS-1:0] kept_r;
  logic [IW-1:0] dayjob_r [MAX_JOBS+1];
  logic [MAX_JOBS:0] dayset_r;
  logic [IW-1:0] cur_dl_r;
  logic out_valid_r;
  dps_pkg::out_item_t out_r;
  dps_pkg::cell_cmd_t cmd;
  dps_pkg::job_t head;
  logic in_fire;

  assign in_ready = (state_r == S_LOAD);
  assign in_fire = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // Saturate incoming deadline lazily at drain, using final count.
  always_comb begin
    cmd = '0;
    cmd.ins = in_fire && (cnt_r < IW'(MAX_JOBS));
    cmd.job.vld = 1'b1;
    cmd.job.dl = in_data.deadline;
    cmd.job.pen = in_data.penalty;
    cmd.job.id = 6'(cnt_r);
    cmd.shift = (state_r == S_DRAIN);
  end

  dps_chain #(.MAX_JOBS(MAX_JOBS)) u_chain (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .head(head)
  );

  function automatic logic hless(logic [IW-1:0] a, logic [IW-1:0] b,
                                 logic [dps_pkg::PEN_W-1:0] pa,
                                 logic [dps_pkg::PEN_W-1:0] pb);
    if (pa != pb) return pa < pb;
    return a < b;
  endfunction

  logic [IW-1:0] par, lc, rc, mm, hid, last_k;
  logic [IW:0] lc_w;
  logic [dps_pkg::DL_W-1:0] head_dl;
  logic [dps_pkg::SUM_W:0] sum_w;
  always_comb begin
    par = (k_r - IW'(1)) >> 1;
    lc_w = {k_r, 1'b1};
    lc = lc_w[IW-1:0];
    rc = lc + IW'(1);
    mm = k_r;
    if (lc_w < (IW+1)'(hsz_r) &&
        hless(heap_r[lc[AW-1:0]], heap_r[mm[AW-1:0]],
              pen_r[heap_r[lc[AW-1:0]][AW-1:0]], pen_r[heap_r[mm[AW-1:0]][AW-1:0]]))
      mm = lc;
    if ((lc_w + 1'b1) < (IW+1)'(hsz_r) &&
        hless(heap_r[rc[AW-1:0]], heap_r[mm[AW-1:0]],
              pen_r[heap_r[rc[AW-1:0]][AW-1:0]], pen_r[heap_r[mm[AW-1:0]][AW-1:0]]))
      mm = rc;
    hid = heap_r[0];
    last_k = hsz_r - IW'(1);
    head_dl = (head.dl > 6'(n_r)) ? 6'(n_r) : head.dl;
    sum_w = {1'b0, sum_r} + (dps_pkg::SUM_W+1)'(pen_r[hid[AW-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      kept_r <= '0;
      dayset_r <= '0;
      sum_r <= '0;
      hsz_r <= '0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (cnt_r < IW'(MAX_JOBS)) begin
              pen_r[cnt_r[AW-1:0]] <= in_data.penalty;
              cnt_r <= cnt_r + IW'(1);
            end
            if (in_data.last) begin
              n_r <= (cnt_r < IW'(MAX_JOBS)) ? cnt_r + IW'(1) : cnt_r;
              idx_r <= '0;
              hsz_r <= '0;
              sum_r <= '0;
              state_r <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (idx_r == n_r) begin
            d_r <= IW'(1);
            idx_r <= '0;
            state_r <= S_SLOT_INIT;
          end else begin
            edl_r[head.id[AW-1:0]] <= head_dl;
            cur_dl_r <= IW'(head_dl);
            heap_r[hsz_r[AW-1:0]] <= IW'(head.id);
            kept_r[head.id[AW-1:0]] <= 1'b1;
            k_r <= hsz_r;
            hsz_r <= hsz_r + IW'(1);
            idx_r <= idx_r + IW'(1);
            state_r <= S_PUSH_UP;
          end
        end
        S_PUSH_UP: begin
          if (k_r != '0 && hless(heap_r[k_r[AW-1:0]], heap_r[par[AW-1:0]],
              pen_r[heap_r[k_r[AW-1:0]][AW-1:0]], pen_r[heap_r[par[AW-1:0]][AW-1:0]])) begin
            heap_r[k_r[AW-1:0]] <= heap_r[par[AW-1:0]];
            heap_r[par[AW-1:0]] <= heap_r[k_r[AW-1:0]];
            k_r <= par;
          end else if (hsz_r > cur_dl_r) begin
            state_r <= S_POP_START;
          end else begin
            state_r <= S_DRAIN;
          end
        end
        S_POP_START: begin
          kept_r[hid[AW-1:0]] <= 1'b0;
          sum_r <= sum_w[dps_pkg::SUM_W] ? dps_pkg::SUM_MAX : sum_w[dps_pkg::SUM_W-1:0];
          heap_r[0] <= heap_r[last_k[AW-1:0]];
          hsz_r <= last_k;
          k_r <= '0;
          state_r <= S_POP_DOWN;
        end
        S_POP_DOWN: begin
          if (mm != k_r) begin
            heap_r[k_r[AW-1:0]] <= heap_r[mm[AW-1:0]];
            heap_r[mm[AW-1:0]] <= heap_r[k_r[AW-1:0]];
            k_r <= mm;
          end else state_r <= S_DRAIN;
        end
        S_SLOT_INIT: begin
          // scan jobs per deadline, ids ascending
          if (d_r > n_r) begin
            d_r <= IW'(1);
            ptr_r <= '0;
            state_r <= S_FILL;
          end else if (idx_r == n_r) begin
            idx_r <= '0;
            d_r <= d_r + IW'(1);
          end else if (kept_r[idx_r[AW-1:0]] && IW'(edl_r[idx_r[AW-1:0]]) == d_r) begin
            root_r <= d_r;
            state_r <= S_SLOT_FIND;
          end else idx_r <= idx_r + IW'(1);
        end
        S_SLOT_FIND: begin
          if (dayset_r[root_r]) root_r <= root_r - IW'(1);
          else if (root_r == '0) begin
            idx_r <= idx_r + IW'(1);
            state_r <= S_SLOT_INIT;
          end else begin
            dayjob_r[root_r] <= idx_r + IW'(1);
            dayset_r[root_r] <= 1'b1;
            idx_r <= idx_r + IW'(1);
            state_r <= S_SLOT_INIT;
          end
        end
        S_FILL: begin
          if (d_r > n_r) begin
            out_r <= '{kind: dps_pkg::KIND_TOTAL, day: '0, job_id: '0,
                       total_penalty: sum_r, final_res: (n_r == '0)};
            out_valid_r <= 1'b1;
            d_r <= IW'(1);
            state_r <= S_OUT_TOTAL;
          end else if (dayset_r[d_r]) d_r <= d_r + IW'(1);
          else if (ptr_r < n_r && kept_r[ptr_r[AW-1:0]]) ptr_r <= ptr_r + IW'(1);
          else begin
            dayjob_r[d_r] <= (ptr_r < n_r) ? ptr_r + IW'(1) : '0;
            if (ptr_r < n_r) ptr_r <= ptr_r + IW'(1);
            d_r <= d_r + IW'(1);
          end
        end
        S_OUT_TOTAL, S_OUT_DAY: begin
          if (out_ready) begin
            if (d_r > n_r) begin
              out_valid_r <= 1'b0;
              cnt_r <= '0;
              kept_r <= '0;
              dayset_r <= '0;
              hsz_r <= '0;
              sum_r <= '0;
              state_r <= S_LOAD;
            end else begin
              out_r <= '{kind: dps_pkg::KIND_DAY, day: 6'(d_r),
                         job_id: 6'(dayjob_r[d_r]), total_penalty: '0,
                         final_res: (d_r == n_r)};
              d_r <= d_r + IW'(1);
              state_r <= S_OUT_DAY;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

@@ hdl/dps_checker.sv @@
// Port-level checks for the deadline penalty scheduler.
module dps_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input dps_pkg::out_item_t out_data
);
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("in dropped");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input open during output");
  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == dps_pkg::KIND_TOTAL |-> out_data.day == '0 &&
    out_data.job_id == '0) else $error("total carries day");
  a_day_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == dps_pkg::KIND_DAY |-> out_data.day != '0 &&
    out_data.total_penalty == '0) else $error("day result malformed");
endmodule

bind deadline_penalty_scheduler_unit dps_checker u_dps_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the deadline penalty scheduler unit.
`timescale 1ns / 100ps

module testbench;
  localparam int NJ = dps_pkg::MAX_JOBS_DEF;
  localparam int DL_W = dps_pkg::DL_W;
  localparam int PEN_W = dps_pkg::PEN_W;
  localparam int SUM_W = dps_pkg::SUM_W;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  dps_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  dps_pkg::out_item_t out_data;

  deadline_penalty_scheduler_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  dps_pkg::in_item_t job_queue[$];
  dps_pkg::out_item_t schedule_queue[$];

  logic [DL_W-1:0] job_dl[NJ];
  logic [PEN_W-1:0] job_pen[NJ];
  int job_cnt;
  int n_fail;
  int n_jobs_sent;
  int n_sets;
  int n_results;
  int in_idle_pct;
  int out_idle_pct;

  function automatic bit cheaper(int a, int b);
    if (job_pen[a] != job_pen[b]) return job_pen[a] < job_pen[b];
    return a < b;
  endfunction

  task automatic schedule_set();
    int n;
    int eff[NJ];
    int order[NJ];
    int heap[NJ];
    int hsz;
    bit kept[NJ];
    int owner[NJ+1];
    int i, j, v, k, p, m, d, dd, ptr, w;
    logic [SUM_W:0] sum;
    dps_pkg::out_item_t r;
    n = job_cnt;
    sum = '0;
    for (i = 0; i < n; i++) begin
      eff[i] = (job_dl[i] > n) ? n : int'(job_dl[i]);
      order[i] = i;
      kept[i] = 0;
    end
    for (i = 0; i <= n; i++) owner[i] = 0;
    for (i = 1; i < n; i++) begin
      v = order[i];
      j = i;
      while (j > 0 && (eff[v] < eff[order[j-1]] ||
             (eff[v] == eff[order[j-1]] && (job_pen[v] > job_pen[order[j-1]] ||
             (job_pen[v] == job_pen[order[j-1]] && v < order[j-1]))))) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
    end
    hsz = 0;
    for (i = 0; i < n; i++) begin
      k = hsz;
      heap[k] = order[i];
      hsz++;
      while (k > 0) begin
        p = (k - 1) / 2;
        if (!cheaper(heap[k], heap[p])) break;
        v = heap[k]; heap[k] = heap[p]; heap[p] = v;
        k = p;
      end
      kept[order[i]] = 1;
      if (hsz > eff[order[i]]) begin
        w = heap[0];
        hsz--;
        heap[0] = heap[hsz];
        k = 0;
        forever begin
          m = k;
          if (2*k+1 < hsz && cheaper(heap[2*k+1], heap[m])) m = 2*k+1;
          if (2*k+2 < hsz && cheaper(heap[2*k+2], heap[m])) m = 2*k+2;
          if (m == k) break;
          v = heap[k]; heap[k] = heap[m]; heap[m] = v;
          k = m;
        end
        kept[w] = 0;
        sum = sum + (SUM_W+1)'(job_pen[w]);
        if (sum > {1'b0, dps_pkg::SUM_MAX}) sum = {1'b0, dps_pkg::SUM_MAX};
      end
    end
    for (d = 1; d <= n; d++)
      for (i = 0; i < n; i++)
        if (kept[i] && eff[i] == d) begin
          dd = d;
          while (dd >= 1 && owner[dd] != 0) dd--;
          if (dd >= 1) owner[dd] = i + 1;
        end
    ptr = 0;
    for (d = 1; d <= n; d++)
      if (owner[d] == 0) begin
        while (ptr < n && kept[ptr]) ptr++;
        if (ptr < n) begin
          owner[d] = ptr + 1;
          ptr++;
        end
      end
    r = '0;
    r.kind = dps_pkg::KIND_TOTAL;
    r.total_penalty = sum[SUM_W-1:0];
    r.final_res = (n == 0);
    schedule_queue = {schedule_queue, r};
    for (d = 1; d <= n; d++) begin
      r = '0;
      r.kind = dps_pkg::KIND_DAY;
      r.day = 6'(d);
      r.job_id = 6'(owner[d]);
      r.final_res = (d == n);
      schedule_queue = {schedule_queue, r};
    end
    job_cnt = 0;
    n_sets++;
  endtask

  task automatic accept_job(dps_pkg::in_item_t it);
    if (job_cnt < NJ) begin
      job_dl[job_cnt] = it.deadline;
      job_pen[job_cnt] = it.penalty;
      job_cnt++;
    end
    n_jobs_sent++;
    if (it.last) schedule_set();
  endtask

  function automatic dps_pkg::in_item_t mk_job(int dl, int pen, bit lst);
    dps_pkg::in_item_t it;
    it.deadline = DL_W'(dl);
    it.penalty = PEN_W'(pen);
    it.last = lst;
    return it;
  endfunction

  task automatic enqueue_job(dps_pkg::in_item_t it);
    job_queue = {job_queue, it};
  endtask

  task automatic queue_random_set(int n);
    int i, mode, dl;
    mode = $urandom_range(0, 3);
    for (i = 0; i < n; i++) begin
      case (mode)
        0: dl = $urandom_range(0, 63);
        1: dl = $urandom_range(0, n);
        2: dl = $urandom_range(1, 3);
        default: dl = $urandom_range(0, 40);
      endcase
      enqueue_job(mk_job(dl,
        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535),
        i == n - 1));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) accept_job(in_data);
      if (job_queue.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= job_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (schedule_queue.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          n_fail++;
        end else begin
          if (out_data !== schedule_queue[0]) begin
            $display("%0t: mismatch expected %p actual %p", $time,
                     schedule_queue[0], out_data);
            n_fail++;
          end
          void'(schedule_queue.pop_front());
        end
      end
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic drain();
    while (job_queue.size() > 0 || in_valid || schedule_queue.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int i, ph;
    rst_n = 1'b0;
    job_cnt = 0;
    n_fail = 0;
    n_jobs_sent = 0;
    n_sets = 0;
    n_results = 0;
    in_idle_pct = 23;
    out_idle_pct = 61;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    enqueue_job(mk_job(0, 65535, 1));
    enqueue_job(mk_job(63, 0, 0));
    enqueue_job(mk_job(32, 65535, 0));
    enqueue_job(mk_job(1, 21845, 0));
    enqueue_job(mk_job(1, 43690, 0));
    enqueue_job(mk_job(0, 1, 1));
    for (i = 0; i < 34; i++)
      enqueue_job(mk_job(1, 65535, i == 33));
    enqueue_job(mk_job(2, 7, 0));
    enqueue_job(mk_job(2, 7, 0));
    enqueue_job(mk_job(2, 7, 1));

    for (ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        in_idle_pct = 61;
        out_idle_pct = 23;
      end else if (ph == 2) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      while (n_jobs_sent + job_queue.size() < 30 + 110 * (ph + 1)) begin
        if ($urandom_range(0, 9) == 0) queue_random_set($urandom_range(20, 34));
        else queue_random_set($urandom_range(1, 10));
      end
      drain();
    end
    repeat (200) @(posedge clk);
    $display("Covered %0d jobs in %0d sets with %0d checked results.",
             n_jobs_sent, n_sets, n_results);
    $display("Included zero and saturated deadlines, overflowing sets, and stall mixes.");
    if (n_fail == 0 && schedule_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
